>>> rtl/pressure_temperature_compensation_defines.svh
// Assertion macros used by the port checker of the compensation block.
// No dependencies; include with the bare file name.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ptc_pkg.sv
// Types and fixed constants of the pressure/temperature compensation block.
// No dependencies.
package ptc_pkg;

   // Field widths
   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 16;
   localparam int IDX_W     = 3;
   localparam int TEMP_W    = 21;
   localparam int PRES_W    = 23;
   localparam int RSP_W     = 48;

   // Datapath widths
   localparam int DT_W      = 25;   // reading minus reference, signed
   localparam int MB_W      = 18;   // second multiplier operand, signed
   localparam int PROD_W    = 43;   // multiplier product, signed
   localparam int SENS_LO_W = 17;   // low, unsigned slice of sensitivity
   localparam int SENS_W    = 35;
   localparam int OFF_W     = 37;
   localparam int FULL_W    = 60;   // sample times sensitivity
   localparam int Q_W       = 39;
   localparam int D_W       = 40;

   // Fixed scaling shifts
   localparam int Q1_SHIFT    = 15;
   localparam int Q2_SHIFT    = 17;
   localparam int Q3_SHIFT    = 7;
   localparam int Q4_SHIFT    = 5;
   localparam int Q5_SHIFT    = 7;
   localparam int Q6_SHIFT    = 21;
   localparam int PRESS_SHIFT = 21;
   localparam int FINAL_SHIFT = 15;
   localparam logic [TEMP_W-1:0] TEMP_BASE = TEMP_W'(2000);

   // Calibration register reset values
   localparam logic [COEF_W-1:0] SENS_RST     = 16'd14980;
   localparam logic [COEF_W-1:0] OFF_RST      = 16'd8468;
   localparam logic [COEF_W-1:0] SENS_TC_RST  = 16'd3624;
   localparam logic [COEF_W-1:0] OFF_TC_RST   = 16'd1743;
   localparam logic [COEF_W-1:0] REF_TEMP_RST = 16'd34934;
   localparam logic [COEF_W-1:0] SLOPE_RST    = 16'd8076;

   typedef enum logic [IDX_W-1:0] {
      CSR_SENS     = 3'd0,
      CSR_OFF      = 3'd1,
      CSR_SENS_TC  = 3'd2,
      CSR_OFF_TC   = 3'd3,
      CSR_REF_TEMP = 3'd4,
      CSR_SLOPE    = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_TEMP  = 1'b0,
      OP_PRESS = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_TEMP,
      ST_MUL_OFF,
      ST_MUL_SENS,
      ST_SENS_ADD,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_COMBINE,
      ST_SCALE,
      ST_SUB_OFF,
      ST_OUTPUT
   } state_type;

endpackage

>>> rtl/pressure_temperature_compensation.sv
// Top level of the pressure/temperature compensation block.
// Depends on ptc_pkg.
//
// A temperature reading (tuser 0) is stored and gives no result; the block
// is ready again on the next cycle. A pressure reading (tuser 1) holds
// req_tready low until the sequencer returns to idle, and longer if the
// previous result still waits in the output register, so the block takes
// no new reading before it is through with a pressure reading.
// The sequence is five passes through one shared 25x18 signed
// multiplier (temperature term, offset term, sensitivity term, then the
// sample times the low and the high half of the sensitivity), each followed
// by a registered add or scaling step, all stepped by one small sequencer.
// Every divide by a power of two rounds toward zero. Calibration words are
// written through the csr port, which is always ready; write them while no
// pressure reading is in flight.
module pressure_temperature_compensation
   import ptc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [23:0] sample
   input  logic                req_tuser,   // [0] op: 0 temperature, 1 pressure
   // result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,   // [22:0] pressure_out, [43:23] temperature_out
   // calibration writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [COEF_W-1:0]   csr_data
);

   state_type state_ff, state_in;

   logic [COEF_W-1:0]   sens_ff, off_coef_ff, sens_tc_ff, off_tc_ff, ref_temp_ff, slope_ff;
   logic [SAMPLE_W-1:0] last_temp_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [DT_W-1:0]     dt_ff, dt_in;

   logic signed [DT_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic                     mul_en;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0]        acc_ff;

   logic [PROD_W-1:0] adj_temp, adj_off, adj_sens;
   logic [TEMP_W-1:0] temp_ff, temp_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [SENS_W-1:0] sens_val_ff, sens_val_in;
   logic [FULL_W-1:0] full_ff, full_in, full_adj;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [D_W-1:0]    d_ff, d_in, d_adj;
   logic [PRES_W-1:0] pres_in;

   logic              req_fire;
   logic              out_free;
   logic              out_load;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PRES_W-1:0] rsp_pres_ff;
   logic [TEMP_W-1:0] rsp_temp_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (state_ff == ST_OUTPUT) && out_free;

   // Calibration registers and the stored temperature reading
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff      <= SENS_RST;
         off_coef_ff  <= OFF_RST;
         sens_tc_ff   <= SENS_TC_RST;
         off_tc_ff    <= OFF_TC_RST;
         ref_temp_ff  <= REF_TEMP_RST;
         slope_ff     <= SLOPE_RST;
         last_temp_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SENS:     sens_ff     <= csr_data;
               CSR_OFF:      off_coef_ff <= csr_data;
               CSR_SENS_TC:  sens_tc_ff  <= csr_data;
               CSR_OFF_TC:   off_tc_ff   <= csr_data;
               CSR_REF_TEMP: ref_temp_ff <= csr_data;
               CSR_SLOPE:    slope_ff    <= csr_data;
               default:      ;
            endcase
         end
         if (req_fire && (req_tuser == OP_TEMP)) begin
            last_temp_ff <= req_tdata;
         end
      end
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and multiplier operand selection
   always_comb begin
      state_in = state_ff;
      mul_a    = $signed(dt_ff);
      mul_b    = '0;
      mul_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == OP_PRESS)) begin
               state_in = ST_MUL_TEMP;
            end
         end
         ST_MUL_TEMP: begin
            mul_b    = $signed({2'b00, slope_ff});
            mul_en   = 1'b1;
            state_in = ST_MUL_OFF;
         end
         ST_MUL_OFF: begin
            mul_b    = $signed({2'b00, off_tc_ff});
            mul_en   = 1'b1;
            state_in = ST_MUL_SENS;
         end
         ST_MUL_SENS: begin
            mul_b    = $signed({2'b00, sens_tc_ff});
            mul_en   = 1'b1;
            state_in = ST_SENS_ADD;
         end
         ST_SENS_ADD: begin
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mul_a    = $signed({1'b0, sample_ff});
            mul_b    = $signed({1'b0, sens_val_ff[SENS_LO_W-1:0]});
            mul_en   = 1'b1;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mul_a    = $signed({1'b0, sample_ff});
            mul_b    = $signed(sens_val_ff[SENS_W-1:SENS_LO_W]);
            mul_en   = 1'b1;
            state_in = ST_COMBINE;
         end
         ST_COMBINE: state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_SUB_OFF;
         ST_SUB_OFF: state_in = ST_OUTPUT;
         ST_OUTPUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath next values; biased adds make each shift round toward zero
   always_comb begin
      dt_in    = {1'b0, last_temp_ff} - {2'b00, ref_temp_ff, {Q5_SHIFT{1'b0}}};
      prod_in  = mul_a * mul_b;
      adj_temp = prod_ff + {{(PROD_W-Q6_SHIFT){1'b0}}, {Q6_SHIFT{prod_ff[PROD_W-1]}}};
      adj_off  = prod_ff + {{(PROD_W-Q4_SHIFT){1'b0}}, {Q4_SHIFT{prod_ff[PROD_W-1]}}};
      adj_sens = prod_ff + {{(PROD_W-Q3_SHIFT){1'b0}}, {Q3_SHIFT{prod_ff[PROD_W-1]}}};
      temp_in  = TEMP_BASE + adj_temp[Q6_SHIFT+TEMP_W-1:Q6_SHIFT];
      off_in   = {{(OFF_W-COEF_W-Q2_SHIFT){1'b0}}, off_coef_ff, {Q2_SHIFT{1'b0}}}
               + adj_off[Q4_SHIFT+OFF_W-1:Q4_SHIFT];
      sens_val_in = {{(SENS_W-COEF_W-Q1_SHIFT){1'b0}}, sens_ff, {Q1_SHIFT{1'b0}}}
                  + adj_sens[Q3_SHIFT+SENS_W-1:Q3_SHIFT];
      // high partial product weighs 2^17 over the low one
      full_in  = {prod_ff, {SENS_LO_W{1'b0}}} + {{(FULL_W-PROD_W){1'b0}}, acc_ff};
      full_adj = full_ff + {{(FULL_W-PRESS_SHIFT){1'b0}}, {PRESS_SHIFT{full_ff[FULL_W-1]}}};
      q_in     = full_adj[FULL_W-1:PRESS_SHIFT];
      d_in     = {{(D_W-Q_W){q_ff[Q_W-1]}}, q_ff} - {{(D_W-OFF_W){off_ff[OFF_W-1]}}, off_ff};
      d_adj    = d_ff + {{(D_W-FINAL_SHIFT){1'b0}}, {FINAL_SHIFT{d_ff[D_W-1]}}};
      pres_in  = d_adj[FINAL_SHIFT+PRES_W-1:FINAL_SHIFT];
   end

   // Datapath registers, each loaded only in the step or steps that produce it
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_tdata;
         dt_ff     <= dt_in;
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_MUL_HI) begin
         acc_ff <= prod_ff;
      end
      if (state_ff == ST_MUL_OFF) begin
         temp_ff <= temp_in;
      end
      if (state_ff == ST_MUL_SENS) begin
         off_ff <= off_in;
      end
      if (state_ff == ST_SENS_ADD) begin
         sens_val_ff <= sens_val_in;
      end
      if (state_ff == ST_COMBINE) begin
         full_ff <= full_in;
      end
      if (state_ff == ST_SCALE) begin
         q_ff <= q_in;
      end
      if (state_ff == ST_SUB_OFF) begin
         d_ff <= d_in;
      end
      if (out_load) begin
         rsp_pres_ff <= pres_in;
         rsp_temp_ff <= temp_ff;
      end
   end

   // Output register valid: set on load, drop once the transaction completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-TEMP_W-PRES_W){1'b0}}, rsp_temp_ff, rsp_pres_ff};

endmodule

>>> rtl/ptc_checker.sv
// Port-level checks for the compensation block, attached by bind.
// Depends on pressure_temperature_compensation_defines.svh.
`include "pressure_temperature_compensation_defines.svh"

module ptc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // A pressure transaction occupies the sequencer on the following cycle
   `PTC_ASSERT_NEXT(a_press_busy, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready, "pressure reading did not make the block busy")

   // A temperature transaction leaves the block ready
   `PTC_ASSERT_NEXT(a_temp_ready, clock, reset, req_tvalid && req_tready && !req_tuser, req_tready, "temperature reading blocked the input")

   // A new result appears only at the end of a busy period
   `PTC_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared without a pressure computation")

   // Hold a stalled result
   `PTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);

>>> verif/ptc_result_checker.sv
// Result checker for the pressure/temperature compensation block: watches the
// reading, result and calibration channels, predicts each result and compares.
// Depends on ptc_pkg.
module ptc_result_checker
   import ptc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  logic                req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RSP_W-1:0]    rsp_tdata,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [COEF_W-1:0]   csr_data,
   output int                  mismatch_count,
   output int                  pending_results
);

   typedef struct packed {
      logic [PRES_W-1:0] pressure;
      logic [TEMP_W-1:0] temperature;
   } comp_result_type;

   // Calibration words and the kept temperature reading
   logic [COEF_W-1:0]   sens_word;
   logic [COEF_W-1:0]   off_word;
   logic [COEF_W-1:0]   sens_tc_word;
   logic [COEF_W-1:0]   off_tc_word;
   logic [COEF_W-1:0]   ref_temp_word;
   logic [COEF_W-1:0]   slope_word;
   logic [SAMPLE_W-1:0] kept_temp;

   comp_result_type expected_readings [$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
   end

   // Compensate one pressure reading against the kept temperature reading.
   // Signed 64-bit division truncates toward zero, as the block must.
   function automatic comp_result_type compensate_reading(input logic [SAMPLE_W-1:0] raw_pres);
      longint t_raw, p_raw, ref_t, slope, off_c, off_tc, sens_c, sens_tc;
      longint dt, temp_c, offset, sens, pres;
      comp_result_type r;
      t_raw   = kept_temp;
      p_raw   = raw_pres;
      ref_t   = ref_temp_word;
      slope   = slope_word;
      off_c   = off_word;
      off_tc  = off_tc_word;
      sens_c  = sens_word;
      sens_tc = sens_tc_word;
      dt      = t_raw - (ref_t <<< Q5_SHIFT);
      temp_c  = 2000 + (dt * slope) / (64'sd1 <<< Q6_SHIFT);
      offset  = (off_c <<< Q2_SHIFT) + (off_tc * dt) / (64'sd1 <<< Q4_SHIFT);
      sens    = (sens_c <<< Q1_SHIFT) + (sens_tc * dt) / (64'sd1 <<< Q3_SHIFT);
      pres    = ((p_raw * sens) / (64'sd1 <<< PRESS_SHIFT) - offset)
                / (64'sd1 <<< FINAL_SHIFT);
      r.pressure    = pres[PRES_W-1:0];
      r.temperature = temp_c[TEMP_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      comp_result_type want;
      logic [PRES_W-1:0] got_pres;
      logic [TEMP_W-1:0] got_temp;
      if (reset) begin
         sens_word     = SENS_RST;
         off_word      = OFF_RST;
         sens_tc_word  = SENS_TC_RST;
         off_tc_word   = OFF_TC_RST;
         ref_temp_word = REF_TEMP_RST;
         slope_word    = SLOPE_RST;
         kept_temp     = '0;
         expected_readings.delete();
      end else begin
         // Compare a result transaction with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_pres = rsp_tdata[PRES_W-1:0];
            got_temp = rsp_tdata[PRES_W +: TEMP_W];
            if (expected_readings.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result pressure %0d temperature %0d", $time,
                        $signed(got_pres), $signed(got_temp));
            end else begin
               want = expected_readings.pop_front();
               if (got_pres !== want.pressure) begin
                  mismatch_count++;
                  $display("%0t: pressure expected %0d actual %0d", $time,
                           $signed(want.pressure), $signed(got_pres));
               end
               if (got_temp !== want.temperature) begin
                  mismatch_count++;
                  $display("%0t: temperature expected %0d actual %0d", $time,
                           $signed(want.temperature), $signed(got_temp));
               end
            end
         end

         // Track calibration writes; unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SENS:     sens_word     = csr_data;
               CSR_OFF:      off_word      = csr_data;
               CSR_SENS_TC:  sens_tc_word  = csr_data;
               CSR_OFF_TC:   off_tc_word   = csr_data;
               CSR_REF_TEMP: ref_temp_word = csr_data;
               CSR_SLOPE:    slope_word    = csr_data;
               default: ;
            endcase
         end

         // Keep temperature readings, predict a result for pressure readings
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_TEMP) begin
               kept_temp = req_tdata;
            end else begin
               expected_readings.push_back(compensate_reading(req_tdata));
            end
         end
      end
      pending_results = expected_readings.size();
   end

endmodule

>>> verif/tb_pressure_temperature_compensation.sv
// Testbench top of the pressure/temperature compensation block: drives
// readings, calibration writes and result backpressure, and gives the verdict.
// Depends on ptc_pkg, ptc_result_checker and the block itself.
module tb_pressure_temperature_compensation;
   import ptc_pkg::*;

   typedef enum int {
      CAL_ZERO,
      CAL_FULL,
      CAL_RANDOM,
      CAL_EXTREME_MIX
   } cal_mode_type;

   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 300;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata  = '0;
   logic                req_tuser  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [IDX_W-1:0]    csr_index  = '0;
   logic [COEF_W-1:0]   csr_data   = '0;

   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int hold_trigger = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int mismatch_count;
   int pending_results;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pressure_temperature_compensation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ptc_result_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // Result backpressure: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Offer one reading after a random gap and hold it until accepted
   task automatic send_reading(input op_type op, input logic [SAMPLE_W-1:0] sample);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_readings(input int count);
      op_type              op;
      logic [SAMPLE_W-1:0] sample;
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(99) < 40) ? OP_TEMP : OP_PRESS;
         case ($urandom_range(9))
            0:       sample = '0;
            1:       sample = '1;
            default: sample = SAMPLE_W'($urandom);
         endcase
         send_reading(op, sample);
      end
   endtask

   // Hold one calibration write until accepted; the caller lowers csr_valid
   task automatic write_cal(input logic [IDX_W-1:0] index, input logic [COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_calibration(input cal_mode_type mode);
      logic [COEF_W-1:0] word;
      for (int i = CSR_SENS; i <= CSR_SLOPE; i++) begin
         case (mode)
            CAL_ZERO: word = '0;
            CAL_FULL: word = '1;
            CAL_RANDOM: word = COEF_W'($urandom);
            default: begin
               case ($urandom_range(2))
                  0:       word = '0;
                  1:       word = '1;
                  default: word = COEF_W'($urandom);
               endcase
            end
         endcase
         write_cal(IDX_W'(i), word);
      end
      // Indexes past the register map must be dropped by the block
      if (mode == CAL_RANDOM) begin
         for (int i = int'(CSR_SLOPE) + 1; i < (1 << IDX_W); i++) begin
            write_cal(IDX_W'(i), COEF_W'($urandom));
         end
      end
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stop offering and let every predicted result drain, then let the block idle
   task automatic drain_results;
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      tx_idle_pct <= 16;
      rx_idle_pct <= 46;
      @(negedge clock);

      // Directed readings under the reset calibration
      send_reading(OP_PRESS, '0);            // pressure with no temperature yet
      send_reading(OP_PRESS, '1);
      send_reading(OP_TEMP,  '0);
      send_reading(OP_PRESS, 24'd123456);
      send_reading(OP_TEMP,  '1);
      send_reading(OP_PRESS, '0);
      send_reading(OP_PRESS, '1);
      send_reading(OP_TEMP,  SAMPLE_W'(REF_TEMP_RST) << Q5_SHIFT);  // zero offset from reference
      send_reading(OP_PRESS, 24'h800000);
      send_reading(OP_TEMP,  24'h555555);
      send_reading(OP_TEMP,  24'hAAAAAA);    // replaces the previous one
      send_reading(OP_PRESS, 24'h555555);
      send_reading(OP_PRESS, 24'hAAAAAA);

      // Random readings with a long result hold-off in the middle
      send_random_readings(40);
      hold_trigger <= hold_trigger + 1;
      send_random_readings(60);
      drain_results();

      load_calibration(CAL_ZERO);
      send_random_readings(60);
      drain_results();

      tx_idle_pct <= 46;
      rx_idle_pct <= 16;
      load_calibration(CAL_FULL);
      send_random_readings(60);
      drain_results();

      load_calibration(CAL_RANDOM);
      send_random_readings(90);
      drain_results();

      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
      load_calibration(CAL_EXTREME_MIX);
      send_random_readings(90);
      drain_results();

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Bound the run well beyond the slowest legal schedule
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> pressure_temperature_compensation.f
+incdir+rtl
rtl/ptc_pkg.sv
rtl/pressure_temperature_compensation.sv
rtl/ptc_checker.sv
verif/ptc_result_checker.sv
verif/tb_pressure_temperature_compensation.sv
